// ===== rtl/core/ipv4e_pkg.sv =====
// ----------------------------------------------------------------------------
// ipv4e_pkg
// Shared types and constants for the IPv4-embedded IPv6 address builder.
// ----------------------------------------------------------------------------
package ipv4e_pkg;

    localparam int unsigned ADDR4_W    = 32;
    localparam int unsigned ADDR6_W    = 128;
    localparam int unsigned HALF6_W    = 64;
    localparam int unsigned LEN_W      = 8;
    localparam int unsigned SUM_W      = 16;
    localparam int unsigned REQ_DATA_W = 176;
    localparam int unsigned RSP_DATA_W = 144;

    localparam logic [LEN_W-1:0] MAX_PREFIX = 8'd128;
    localparam logic [LEN_W-1:0] MAX_DROP   = 8'd32;

    typedef struct packed {
        logic [HALF6_W-1:0] prefix_low;
        logic [HALF6_W-1:0] prefix_high;
        logic [LEN_W-1:0]   prefix_len;
        logic [LEN_W-1:0]   drop_bits;
        logic [ADDR4_W-1:0] ipv4_addr;
    } t_req;

    typedef struct packed {
        logic               entry_bad;
        logic [SUM_W-1:0]   sum_delta;
        logic [HALF6_W-1:0] ipv6_low;
        logic [HALF6_W-1:0] ipv6_high;
    } t_rsp;

endpackage

// ===== rtl/core/ipv4_in_ipv6_address_embed.sv =====
// ----------------------------------------------------------------------------
// ipv4_in_ipv6_address_embed
// Builds an IPv4-embedded IPv6 address and its checksum delta per item.
// ----------------------------------------------------------------------------
// Each item carries an IPv4 address and a mapping entry (prefix, prefix
// length, dropped IPv4 bits); the result is the 128-bit address with the
// low IPv4 bits placed right below the kept prefix bits, the folded 16-bit
// ones'-complement checksum delta, and a flag for entries whose lengths are
// out of range (address and delta then read zero). The block accepts one
// item per cycle while its output is not stalled; each item passes one input
// register, the mask/shift/adder-tree logic, then the output register.
// A stalled output holds only its own item; the input register keeps
// accepting until both registers are full.
module ipv4_in_ipv6_address_embed (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // ipv4_addr[31:0], drop_bits[39:32], prefix_len[47:40],
    // prefix_high[111:48], prefix_low[175:112]
    input  logic [ipv4e_pkg::REQ_DATA_W-1:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // ipv6_high[63:0], ipv6_low[127:64], sum_delta[143:128]
    output logic [ipv4e_pkg::RSP_DATA_W-1:0] m_axis_tdata,
    // entry_bad[0]
    output logic         m_axis_tuser
);

    ipv4e_pkg::t_req r_req;
    logic            r_req_valid;
    ipv4e_pkg::t_rsp r_rsp;
    logic            r_rsp_valid;
    ipv4e_pkg::t_rsp rsp;
    logic            out_adv;
    logic            in_take;

    assign out_adv       = !r_rsp_valid || m_axis_tready;
    assign s_axis_tready = !r_req_valid || out_adv;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    ipv4e_embed u_embed (
        .i_req (r_req),
        .o_rsp (rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
            r_rsp_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_req_valid <= s_axis_tvalid;
            end
            if (out_adv) begin
                r_rsp_valid <= r_req_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_req <= ipv4e_pkg::t_req'(s_axis_tdata);
        end
        if (out_adv && r_req_valid) begin
            r_rsp <= rsp;
        end
    end

    assign m_axis_tvalid = r_rsp_valid;
    assign m_axis_tdata  = {r_rsp.sum_delta, r_rsp.ipv6_low, r_rsp.ipv6_high};
    assign m_axis_tuser  = r_rsp.entry_bad;

endmodule

// ===== rtl/core/ipv4e_embed.sv =====
// ----------------------------------------------------------------------------
// ipv4e_embed
// Length checks, prefix mask, IPv4 embedding and checksum delta for one item.
// ----------------------------------------------------------------------------
module ipv4e_embed (
    input  ipv4e_pkg::t_req i_req,
    output ipv4e_pkg::t_rsp o_rsp
);

    logic                              len_ok;
    logic [8:0]                        span;
    logic [5:0]                        emb_n;
    logic [ipv4e_pkg::ADDR4_W-1:0]     emb;
    logic [7:0]                        emb_shift;
    logic [ipv4e_pkg::ADDR6_W-1:0]     keep;
    logic [ipv4e_pkg::ADDR6_W-1:0]     addr;
    logic [34:0]                       sum0;
    logic [32:0]                       sum1;
    logic [31:0]                       sum2;
    logic [16:0]                       sum3;
    logic [15:0]                       sum4;

    always_comb begin
        span   = {1'b0, i_req.prefix_len} + 9'd32 - {1'b0, i_req.drop_bits};
        len_ok = (i_req.prefix_len <= ipv4e_pkg::MAX_PREFIX)
              && (i_req.drop_bits <= ipv4e_pkg::MAX_DROP)
              && (span <= {1'b0, ipv4e_pkg::MAX_PREFIX});

        emb_n     = 6'(ipv4e_pkg::MAX_DROP - i_req.drop_bits);
        emb       = i_req.ipv4_addr & ~({ipv4e_pkg::ADDR4_W{1'b1}} << emb_n);
        emb_shift = ipv4e_pkg::MAX_PREFIX - i_req.prefix_len - {2'b00, emb_n};

        keep = ~({ipv4e_pkg::ADDR6_W{1'b1}} >> i_req.prefix_len);
        addr = ({i_req.prefix_high, i_req.prefix_low} & keep)
             | ({96'd0, emb} << emb_shift);

        sum0 = {3'b000, ~i_req.ipv4_addr}
             + {3'b000, addr[127:96]} + {3'b000, addr[95:64]}
             + {3'b000, addr[63:32]}  + {3'b000, addr[31:0]};
        sum1 = {1'b0, sum0[31:0]} + {30'd0, sum0[34:32]};
        sum2 = sum1[31:0] + {31'd0, sum1[32]};
        sum3 = {1'b0, sum2[15:0]} + {1'b0, sum2[31:16]};
        sum4 = sum3[15:0] + {15'd0, sum3[16]};

        if (len_ok) begin
            o_rsp.ipv6_high = addr[127:64];
            o_rsp.ipv6_low  = addr[63:0];
            o_rsp.sum_delta = sum4;
            o_rsp.entry_bad = 1'b0;
        end else begin
            o_rsp.ipv6_high = '0;
            o_rsp.ipv6_low  = '0;
            o_rsp.sum_delta = '0;
            o_rsp.entry_bad = 1'b1;
        end
    end

endmodule

// ===== rtl/core/ipv4e_checker.sv =====
// ----------------------------------------------------------------------------
// ipv4e_checker
// Port-level checks for the IPv4-embedded IPv6 address builder.
// ----------------------------------------------------------------------------
module ipv4e_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [ipv4e_pkg::RSP_DATA_W-1:0] m_axis_tdata,
    input logic         m_axis_tuser
);

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("bad entry with nonzero data");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
        (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled item changed");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)
        else $error("input stalled while output free");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (!m_axis_tvalid && s_axis_tready))
        else $error("pipeline not empty after reset");

endmodule

bind ipv4_in_ipv6_address_embed ipv4e_checker u_ipv4e_checker (.*);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the IPv4-embedded IPv6 address builder.
// ----------------------------------------------------------------------------
// A table of directed entries comes first: zero and all-ones addresses,
// rejected lengths, full pass-through, everything dropped, word-aligned and
// word-straddling prefixes. Random entries follow in three phases with
// different source/sink idle rates. Every result is checked field by field
// against table values or an in-bench address builder, in order of acceptance.
module tb;

    localparam int DIR_N     = 25;
    localparam int PHASE_N   = 300;
    localparam int HOLD_LEN  = 60;
    localparam logic [63:0] ONES = '1;
    localparam logic [63:0] PH   = 64'h2001_0db8_1234_5678;
    localparam logic [63:0] PL   = 64'h9abc_def0_0fed_cba9;
    localparam int unsigned BOUNDS [8] = '{0, 32, 40, 48, 56, 64, 96, 128};

    typedef struct packed {
        logic [31:0] addr4;
        logic [7:0]  drop;
        logic [7:0]  plen;
        logic [63:0] pfx_hi;
        logic [63:0] pfx_lo;
        logic        typed;
        logic [63:0] want_hi;
        logic [63:0] want_lo;
        logic [15:0] want_sum;
        logic        want_bad;
    } t_dir_row;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [175:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [143:0] m_axis_tdata;
    logic         m_axis_tuser;

    ipv4e_pkg::t_rsp pending_addrs [$];
    int   mismatch_cnt = 0;
    int   result_idx = 0;
    int   snd_idle_pct = 13;
    int   rcv_idle_pct = 70;
    int   hold_req = 0;
    int   hold_seen = 0;
    int   hold_left = 0;

    t_dir_row dir_rows [DIR_N] = '{
        '{32'h0000_0000, 8'd0,   8'd0,   64'h0, 64'h0, 1'b1,
          64'h0, 64'h0, 16'hffff, 1'b0},
        '{32'hffff_ffff, 8'd0,   8'd0,   64'h0, 64'h0, 1'b1,
          64'hffff_ffff_0000_0000, 64'h0, 16'hffff, 1'b0},
        '{32'hffff_ffff, 8'd0,   8'd129, ONES, ONES, 1'b1, 64'h0, 64'h0, 16'h0, 1'b1},
        '{32'hffff_ffff, 8'd33,  8'd0,   ONES, ONES, 1'b1, 64'h0, 64'h0, 16'h0, 1'b1},
        '{32'hffff_ffff, 8'd255, 8'd255, ONES, ONES, 1'b1, 64'h0, 64'h0, 16'h0, 1'b1},
        '{32'hc000_0201, 8'd0,   8'd97,  PH,   PL,   1'b1, 64'h0, 64'h0, 16'h0, 1'b1},
        '{32'hc000_0201, 8'd31,  8'd128, ONES, ONES, 1'b1, 64'h0, 64'h0, 16'h0, 1'b1},
        '{32'hc000_0201, 8'd0,   8'd128, ONES, ONES, 1'b1, 64'h0, 64'h0, 16'h0, 1'b1},
        '{32'hc000_0201, 8'd0,   8'd96,  PH,   PL,   1'b0, 64'h0, 64'h0, 16'h0, 1'b0},
        '{32'hc000_0201, 8'd32,  8'd128, PH,   PL,   1'b0, 64'h0, 64'h0, 16'h0, 1'b0},
        '{32'hffff_ffff, 8'd0,   8'd64,  PH,   PL,   1'b0, 64'h0, 64'h0, 16'h0, 1'b0},
        '{32'ha5a5_a5a5, 8'd0,   8'd32,  PH,   PL,   1'b0, 64'h0, 64'h0, 16'h0, 1'b0},
        '{32'ha5a5_a5a5, 8'd0,   8'd40,  PH,   PL,   1'b0, 64'h0, 64'h0, 16'h0, 1'b0},
        '{32'h5a5a_5a5a, 8'd0,   8'd48,  ONES, ONES, 1'b0, 64'h0, 64'h0, 16'h0, 1'b0},
        '{32'h5a5a_5a5a, 8'd0,   8'd56,  PH,   PL,   1'b0, 64'h0, 64'h0, 16'h0, 1'b0},
        '{32'hdead_beef, 8'd0,   8'd63,  PH,   PL,   1'b0, 64'h0, 64'h0, 16'h0, 1'b0},
        '{32'hdead_beef, 8'd32,  8'd0,   ONES, ONES, 1'b0, 64'h0, 64'h0, 16'h0, 1'b0},
        '{32'hdead_beef, 8'd32,  8'd64,  ONES, ONES, 1'b0, 64'h0, 64'h0, 16'h0, 1'b0},
        '{32'hffff_ffff, 8'd31,  8'd127, PH,   PL,   1'b0, 64'h0, 64'h0, 16'h0, 1'b0},
        '{32'hffff_ffff, 8'd32,  8'd127, ONES, ONES, 1'b0, 64'h0, 64'h0, 16'h0, 1'b0},
        '{32'h0000_0000, 8'd0,   8'd96,  ONES, ONES, 1'b0, 64'h0, 64'h0, 16'h0, 1'b0},
        '{32'h1234_5678, 8'd8,   8'd50,  PH,   PL,   1'b0, 64'h0, 64'h0, 16'h0, 1'b0},
        '{32'h89ab_cdef, 8'd16,  8'd80,  ONES, ONES, 1'b0, 64'h0, 64'h0, 16'h0, 1'b0},
        '{32'h0000_0001, 8'd24,  8'd120, PH,   PL,   1'b0, 64'h0, 64'h0, 16'h0, 1'b0},
        '{32'h8000_0000, 8'd0,   8'd0,   ONES, ONES, 1'b0, 64'h0, 64'h0, 16'h0, 1'b0}
    };

    ipv4_in_ipv6_address_embed uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic ipv4e_pkg::t_rsp build_embedded_addr(input ipv4e_pkg::t_req r);
        ipv4e_pkg::t_rsp o;
        logic [127:0] keep_mask;
        logic [127:0] addr;
        logic [127:0] emb;
        logic [63:0]  acc;
        int unsigned  p;
        int unsigned  d;
        int unsigned  n;
        o = '0;
        p = r.prefix_len;
        d = r.drop_bits;
        if (p > ipv4e_pkg::MAX_PREFIX || d > ipv4e_pkg::MAX_DROP
                || p + ipv4e_pkg::ADDR4_W - d > ipv4e_pkg::ADDR6_W) begin
            o.entry_bad = 1'b1;
            return o;
        end
        keep_mask = (p == 0) ? '0 : ({128{1'b1}} << (ipv4e_pkg::ADDR6_W - p));
        addr = {r.prefix_high, r.prefix_low} & keep_mask;
        n = ipv4e_pkg::ADDR4_W - d;
        emb = (n == 0) ? '0 : (128'(r.ipv4_addr) & ((128'(1) << n) - 128'(1)));
        addr = addr | (emb << (ipv4e_pkg::ADDR6_W - p - n));
        acc = {32'd0, ~r.ipv4_addr} + addr[127:96] + addr[95:64] + addr[63:32]
            + addr[31:0];
        acc = acc[31:0] + acc[63:32];
        acc = acc[31:0] + acc[63:32];
        acc = acc[15:0] + acc[31:16];
        acc = acc[15:0] + acc[31:16];
        o.ipv6_high = addr[127:64];
        o.ipv6_low  = addr[63:0];
        o.sum_delta = acc[15:0];
        return o;
    endfunction

    function automatic logic [63:0] random_half();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic ipv4e_pkg::t_req random_entry();
        ipv4e_pkg::t_req r;
        int unsigned k;
        int unsigned p;
        int unsigned dmin;
        r.ipv4_addr   = $urandom;
        r.prefix_high = random_half();
        r.prefix_low  = random_half();
        k = $urandom_range(99);
        if (k < 12) begin
            r.prefix_len = 8'($urandom_range(255));
            r.drop_bits  = 8'($urandom_range(255));
        end else if (k < 20) begin
            p = $urandom_range(128, 97);
            r.prefix_len = 8'(p);
            r.drop_bits  = 8'(p - 97);
        end else begin
            p = (k < 45) ? BOUNDS[$urandom_range(7)] : $urandom_range(128);
            dmin = (p > 96) ? p - 96 : 0;
            r.prefix_len = 8'(p);
            r.drop_bits  = 8'($urandom_range(32, dmin));
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch on result %0d: %s got %h expected %h",
                 result_idx, what, got, want);
        mismatch_cnt++;
    endtask

    task automatic send_item(input ipv4e_pkg::t_req r, input ipv4e_pkg::t_rsp want);
        while ($urandom_range(99) < snd_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= r;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_addrs.push_back(want);
        @(negedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending_addrs.size() != 0);
    endtask

    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        ipv4e_pkg::t_rsp got;
        ipv4e_pkg::t_rsp want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tuser, m_axis_tdata};
            if (pending_addrs.size() == 0) begin
                report_mismatch("unexpected result, ipv6_high", got.ipv6_high, 64'h0);
            end else begin
                want = pending_addrs.pop_front();
                if (got.ipv6_high !== want.ipv6_high)
                    report_mismatch("ipv6_high", got.ipv6_high, want.ipv6_high);
                if (got.ipv6_low !== want.ipv6_low)
                    report_mismatch("ipv6_low", got.ipv6_low, want.ipv6_low);
                if (got.sum_delta !== want.sum_delta)
                    report_mismatch("sum_delta", 64'(got.sum_delta), 64'(want.sum_delta));
                if (got.entry_bad !== want.entry_bad)
                    report_mismatch("entry_bad", 64'(got.entry_bad), 64'(want.entry_bad));
            end
            result_idx++;
        end
    end

    initial begin
        ipv4e_pkg::t_req r;
        ipv4e_pkg::t_rsp want;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        for (int i = 0; i < DIR_N; i++) begin
            r.ipv4_addr   = dir_rows[i].addr4;
            r.drop_bits   = dir_rows[i].drop;
            r.prefix_len  = dir_rows[i].plen;
            r.prefix_high = dir_rows[i].pfx_hi;
            r.prefix_low  = dir_rows[i].pfx_lo;
            if (dir_rows[i].typed) begin
                want.ipv6_high = dir_rows[i].want_hi;
                want.ipv6_low  = dir_rows[i].want_lo;
                want.sum_delta = dir_rows[i].want_sum;
                want.entry_bad = dir_rows[i].want_bad;
            end else begin
                want = build_embedded_addr(r);
            end
            send_item(r, want);
        end
        for (int ph = 0; ph < 3; ph++) begin
            drain();
            case (ph)
                0: begin
                    snd_idle_pct = 13;
                    rcv_idle_pct = 70;
                end
                1: begin
                    snd_idle_pct = 70;
                    rcv_idle_pct = 13;
                end
                default: begin
                    snd_idle_pct = 0;
                    rcv_idle_pct = 0;
                end
            endcase
            for (int i = 0; i < PHASE_N; i++) begin
                if (i == 100)
                    hold_req++;
                r = random_entry();
                send_item(r, build_embedded_addr(r));
            end
        end
        s_axis_tvalid <= 1'b0;
        while (pending_addrs.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
